// ===== sv/bgc_pkg.sv =====
// Package with shared types, constants and helper functions of the button gesture classifier.
package bgc_pkg;

   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CMP_BITS = (TIMER_BITS > CFG_BITS + 2) ? TIMER_BITS : CFG_BITS + 2;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [CFG_BITS-1:0] cfg_word_type;
   typedef logic [CMP_BITS-1:0] cmp_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ACTIVE_HIGH   = 4'd0,
      REG_DOUBLE_ENABLE = 4'd1,
      REG_LONG_ONCE     = 4'd2,
      REG_HOLD_TICKS    = 4'd3,
      REG_REST_TICKS    = 4'd4,
      REG_LONG_TICKS    = 4'd5,
      REG_DOUBLE_WINDOW = 4'd6,
      REG_DEBOUNCE      = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_REST   = 3'd1,
      ST_BOUNCE = 3'd2,
      ST_DONE   = 3'd3,
      ST_BUSY   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      G_NONE   = 2'd0,
      G_SHORT  = 2'd1,
      G_DOUBLE = 2'd2,
      G_LONG   = 2'd3
   } gesture_type;

   typedef struct packed {
      logic         active_high;
      logic         double_enable;
      logic         long_once;
      cfg_word_type hold_ticks;
      cfg_word_type rest_ticks;
      cfg_word_type long_ticks;
      cfg_word_type double_window_ticks;
      cfg_word_type debounce_ticks;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      gesture_type gesture;
      logic        short_event;
      logic        double_event;
      logic        long_event;
   } rsp_type;

   function automatic timer_type sat_inc(input timer_type t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   function automatic cmp_type widen_timer(input timer_type t);
      return cmp_type'(t);
   endfunction

   function automatic cmp_type widen_cfg(input cfg_word_type v);
      return cmp_type'(v);
   endfunction

endpackage

// ===== sv/bgc_req_if.sv =====
// Input channel carrying one raw pin sample per word.
interface bgc_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

// ===== sv/bgc_rsp_if.sv =====
// Result channel carrying status, held gesture and event pulses per word.
interface bgc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [1:0] gesture;
   logic       short_event;
   logic       double_event;
   logic       long_event;

   modport source (output valid, output status, output gesture, output short_event,
                   output double_event, output long_event, input ready);
   modport sink (input valid, input status, input gesture, input short_event,
                 input double_event, input long_event, output ready);
endinterface

// ===== sv/bgc_csr_if.sv =====
// Configuration write channel carrying a register index and write data.
interface bgc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bgc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [bgc_pkg::CFG_BITS-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/button_gesture_classifier_unit.sv =====
// Top level of the button gesture classifier: channel registers around the gesture state machine.
//
// Usage: each word on the req_port channel is one raw pin sample, one per tick. For every
// accepted word exactly one word leaves on rsp_port: a status code, the held gesture and
// the short, double and long event pulses for that tick.
// The csr_port channel writes the eight configuration registers by index; it is always
// ready, and writes are meant for times when no sample is in flight.
// A sample passes an input register; once the output register is free or being read, the
// state machine updates and the result lands in the output register at the same edge.
// One sample is accepted every cycle while the receiver takes each result; the state
// machine's timer and phase update is the loop that sets this rate.
// When the receiver stalls, the output register holds its word and the input register
// holds one more sample; req_port.ready drops only when both are full.
// Reset is synchronous: both channel registers empty, the configuration returns to its
// defaults and the classifier goes idle with no rest period and no held gesture.
module button_gesture_classifier_unit (
   input logic       clock,
   input logic       reset,
   bgc_req_if.sink   req_port,
   bgc_rsp_if.source rsp_port,
   bgc_csr_if.sink   csr_port
);

   bgc_pkg::cfg_type cfg;
   bgc_pkg::rsp_type step_rsp;

   logic             s1_valid_ff;
   logic             s1_pin_ff;
   logic             rsp_valid_ff;
   bgc_pkg::rsp_type rsp_data_ff;
   logic             out_take;
   logic             step_en;

   assign out_take = !rsp_valid_ff || rsp_port.ready;
   assign step_en = s1_valid_ff && out_take;
   assign req_port.ready = !s1_valid_ff || out_take;
   assign csr_port.ready = 1'b1;

   bgc_csr_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_port.valid),
      .wr_index (csr_port.index),
      .wr_data  (csr_port.data),
      .cfg      (cfg)
   );

   bgc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .pin_level (s1_pin_ff),
      .cfg       (cfg),
      .rsp       (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_port.ready) begin
            s1_valid_ff <= req_port.valid;
            s1_pin_ff <= req_port.pin_level;
         end
         if (out_take) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (step_en) begin
            rsp_data_ff <= step_rsp;
         end
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.status = rsp_data_ff.status;
   assign rsp_port.gesture = rsp_data_ff.gesture;
   assign rsp_port.short_event = rsp_data_ff.short_event;
   assign rsp_port.double_event = rsp_data_ff.double_event;
   assign rsp_port.long_event = rsp_data_ff.long_event;

endmodule

// ===== sv/bgc_csr_regs.sv =====
// Configuration register file of the button gesture classifier.
module bgc_csr_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  bgc_pkg::csr_index_type wr_index,
   input  bgc_pkg::cfg_word_type  wr_data,
   output bgc_pkg::cfg_type   cfg
);

   bgc_pkg::cfg_type cfg_ff;
   bgc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            bgc_pkg::REG_ACTIVE_HIGH:   cfg_in.active_high = wr_data[0];
            bgc_pkg::REG_DOUBLE_ENABLE: cfg_in.double_enable = wr_data[0];
            bgc_pkg::REG_LONG_ONCE:     cfg_in.long_once = wr_data[0];
            bgc_pkg::REG_HOLD_TICKS:    cfg_in.hold_ticks = wr_data;
            bgc_pkg::REG_REST_TICKS:    cfg_in.rest_ticks = wr_data;
            bgc_pkg::REG_LONG_TICKS:    cfg_in.long_ticks = wr_data;
            bgc_pkg::REG_DOUBLE_WINDOW: cfg_in.double_window_ticks = wr_data;
            bgc_pkg::REG_DEBOUNCE:      cfg_in.debounce_ticks = wr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high <= 1'b1;
         cfg_ff.double_enable <= 1'b0;
         cfg_ff.long_once <= 1'b0;
         cfg_ff.hold_ticks <= bgc_pkg::CFG_BITS'(500);
         cfg_ff.rest_ticks <= bgc_pkg::CFG_BITS'(20);
         cfg_ff.long_ticks <= bgc_pkg::CFG_BITS'(1000);
         cfg_ff.double_window_ticks <= bgc_pkg::CFG_BITS'(300);
         cfg_ff.debounce_ticks <= bgc_pkg::CFG_BITS'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/bgc_classify.sv =====
// Gesture state machine: debounce, press classification, hold and rest timers.
module bgc_classify (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic             pin_level,
   input  bgc_pkg::cfg_type cfg,
   output bgc_pkg::rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_DEBOUNCE  = 3'd1,
      PH_DETERMINE = 3'd2,
      PH_SHORT     = 3'd3,
      PH_DOUBLE    = 3'd4,
      PH_LONG      = 3'd5,
      PH_END       = 3'd6
   } phase_type;

   phase_type              phase_ff, phase_in;
   bgc_pkg::timer_type     phase_timer_ff, phase_timer_in;
   bgc_pkg::timer_type     rest_timer_ff, rest_timer_in;
   logic                   pend_clear_ff, pend_clear_in;
   bgc_pkg::gesture_type   held_ff, held_in;

   logic                   pressed;
   bgc_pkg::timer_type     rest_inc;
   bgc_pkg::timer_type     phase_inc;
   bgc_pkg::cmp_type       double_gap;

   assign pressed = (pin_level == cfg.active_high);
   assign rest_inc = bgc_pkg::sat_inc(rest_timer_ff);
   assign phase_inc = bgc_pkg::sat_inc(phase_timer_ff);
   assign double_gap = bgc_pkg::widen_cfg(cfg.rest_ticks)
                     + (bgc_pkg::widen_cfg(cfg.debounce_ticks) << 1);

   always_comb begin
      phase_in = phase_ff;
      phase_timer_in = phase_timer_ff;
      rest_timer_in = rest_inc;
      pend_clear_in = pend_clear_ff;
      held_in = held_ff;
      rsp.status = bgc_pkg::ST_BUSY;
      rsp.short_event = 1'b0;
      rsp.double_event = 1'b0;
      rsp.long_event = 1'b0;

      if (bgc_pkg::widen_timer(rest_inc) < bgc_pkg::widen_cfg(cfg.rest_ticks)) begin
         rsp.status = bgc_pkg::ST_REST;
      end else begin
         if (pend_clear_ff &&
             (bgc_pkg::widen_timer(rest_inc) > bgc_pkg::widen_cfg(cfg.hold_ticks))) begin
            pend_clear_in = 1'b0;
            held_in = bgc_pkg::G_NONE;
         end
         unique case (phase_ff)
            PH_IDLE: begin
               if (pressed) begin
                  phase_in = PH_DEBOUNCE;
                  phase_timer_in = '0;
               end else begin
                  rsp.status = bgc_pkg::ST_IDLE;
               end
            end
            PH_DEBOUNCE: begin
               if (!pressed) begin
                  phase_in = PH_IDLE;
                  rsp.status = bgc_pkg::ST_BOUNCE;
               end else if (bgc_pkg::widen_timer(phase_inc) >=
                            bgc_pkg::widen_cfg(cfg.debounce_ticks)) begin
                  phase_in = PH_DETERMINE;
                  phase_timer_in = '0;
               end else begin
                  phase_timer_in = phase_inc;
               end
            end
            PH_DETERMINE: begin
               phase_timer_in = phase_inc;
               if (!pressed) begin
                  phase_in = PH_SHORT;
               end else if (bgc_pkg::widen_timer(phase_inc) >=
                            bgc_pkg::widen_cfg(cfg.long_ticks)) begin
                  phase_in = PH_LONG;
               end
            end
            PH_SHORT: begin
               if (cfg.double_enable) begin
                  phase_timer_in = phase_inc;
                  if (pressed && (bgc_pkg::widen_timer(phase_inc) >= double_gap)) begin
                     phase_in = PH_DOUBLE;
                  end else if (bgc_pkg::widen_timer(phase_inc) >=
                               bgc_pkg::widen_cfg(cfg.double_window_ticks)) begin
                     held_in = bgc_pkg::G_SHORT;
                     rsp.short_event = 1'b1;
                     phase_in = PH_END;
                  end
               end else begin
                  held_in = bgc_pkg::G_SHORT;
                  rsp.short_event = 1'b1;
                  phase_in = PH_END;
               end
            end
            PH_DOUBLE: begin
               held_in = bgc_pkg::G_DOUBLE;
               rsp.double_event = 1'b1;
               if (!pressed) begin
                  phase_in = PH_END;
               end
            end
            PH_LONG: begin
               held_in = bgc_pkg::G_LONG;
               rsp.long_event = 1'b1;
               if (!pressed || cfg.long_once) begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               if (!pressed) begin
                  phase_in = PH_IDLE;
                  rest_timer_in = '0;
                  pend_clear_in = 1'b1;
                  rsp.status = bgc_pkg::ST_DONE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               rsp.status = bgc_pkg::ST_IDLE;
            end
         endcase
      end
      rsp.gesture = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         phase_timer_ff <= '0;
         rest_timer_ff <= '1;
         pend_clear_ff <= 1'b0;
         held_ff <= bgc_pkg::G_NONE;
      end else if (step_en) begin
         phase_ff <= phase_in;
         phase_timer_ff <= phase_timer_in;
         rest_timer_ff <= rest_timer_in;
         pend_clear_ff <= pend_clear_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== sv/bgc_checker.sv =====
// Port-level assertions for the button gesture classifier and their bind to the top level.
module bgc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [1:0] rsp_gesture,
   input logic       rsp_short_event,
   input logic       rsp_double_event,
   input logic       rsp_long_event
);

   // At most one gesture event is reported in one word.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_short_event, rsp_double_event, rsp_long_event}) <= 1)
      else $error("more than one event pulse in one word");

   // An event pulse always comes with the matching held gesture.
   a_event_gesture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_short_event || rsp_gesture == bgc_pkg::G_SHORT) &&
                     (!rsp_double_event || rsp_gesture == bgc_pkg::G_DOUBLE) &&
                     (!rsp_long_event || rsp_gesture == bgc_pkg::G_LONG)))
      else $error("event pulse without the matching held gesture");

   // Events are only reported while a gesture is in progress.
   a_event_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_short_event || rsp_double_event || rsp_long_event))
         |-> rsp_status == bgc_pkg::ST_BUSY)
      else $error("event pulse outside the in-progress status");

   // No result word is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_gesture) && $stable(rsp_short_event) &&
         $stable(rsp_double_event) && $stable(rsp_long_event)))
      else $error("stalled result word changed");

endmodule

bind button_gesture_classifier_unit bgc_checker u_bgc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_status       (rsp_port.status),
   .rsp_gesture      (rsp_port.gesture),
   .rsp_short_event  (rsp_port.short_event),
   .rsp_double_event (rsp_port.double_event),
   .rsp_long_event   (rsp_port.long_event)
);

// ===== verif/bgc_gesture_checker.sv =====
// Checker that predicts every result word of the gesture classifier and compares it on arrival.
module bgc_gesture_checker
   import bgc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bgc_req_if   req_mon,
   bgc_rsp_if   rsp_mon,
   bgc_csr_if   csr_mon,
   output int   failures,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DEBOUNCE,
      PH_DETERMINE,
      PH_SHORT_WAIT,
      PH_DOUBLE,
      PH_LONG,
      PH_END
   } press_phase_type;

   localparam cfg_type RESET_CFG = '{1'b1, 1'b0, 1'b0, 16'd500, 16'd20, 16'd1000, 16'd300, 16'd10};

   cfg_type         cfg;
   press_phase_type phase;
   timer_type       phase_timer;
   timer_type       rest_timer;
   logic            clear_pending;
   gesture_type     held;
   rsp_type         expected_words[$];

   function automatic timer_type bump(input timer_type t);
      if (&t) begin
         return t;
      end
      return t + 1'b1;
   endfunction

   task automatic classify_sample(input logic pin_level, output rsp_type word);
      logic       pressed;
      status_type st;
      logic       ev_short;
      logic       ev_double;
      logic       ev_long;
      pressed = (pin_level == cfg.active_high);
      st = ST_BUSY;
      ev_short = 1'b0;
      ev_double = 1'b0;
      ev_long = 1'b0;
      rest_timer = bump(rest_timer);
      if (rest_timer < cfg.rest_ticks) begin
         st = ST_REST;
      end else begin
         if (clear_pending && rest_timer > cfg.hold_ticks) begin
            clear_pending = 1'b0;
            held = G_NONE;
         end
         case (phase)
            PH_IDLE: begin
               if (pressed) begin
                  phase = PH_DEBOUNCE;
                  phase_timer = '0;
               end else begin
                  st = ST_IDLE;
               end
            end
            PH_DEBOUNCE: begin
               if (!pressed) begin
                  phase = PH_IDLE;
                  st = ST_BOUNCE;
               end else begin
                  phase_timer = bump(phase_timer);
                  if (phase_timer >= cfg.debounce_ticks) begin
                     phase = PH_DETERMINE;
                     phase_timer = '0;
                  end
               end
            end
            PH_DETERMINE: begin
               phase_timer = bump(phase_timer);
               if (!pressed) begin
                  phase = PH_SHORT_WAIT;
               end else if (phase_timer >= cfg.long_ticks) begin
                  phase = PH_LONG;
               end
            end
            PH_SHORT_WAIT: begin
               if (cfg.double_enable) begin
                  phase_timer = bump(phase_timer);
                  if (pressed && int'(phase_timer) >=
                      int'(cfg.rest_ticks) + 2 * int'(cfg.debounce_ticks)) begin
                     phase = PH_DOUBLE;
                  end else if (phase_timer >= cfg.double_window_ticks) begin
                     held = G_SHORT;
                     ev_short = 1'b1;
                     phase = PH_END;
                  end
               end else begin
                  held = G_SHORT;
                  ev_short = 1'b1;
                  phase = PH_END;
               end
            end
            PH_DOUBLE: begin
               held = G_DOUBLE;
               ev_double = 1'b1;
               if (!pressed) begin
                  phase = PH_END;
               end
            end
            PH_LONG: begin
               held = G_LONG;
               ev_long = 1'b1;
               if (!pressed || cfg.long_once) begin
                  phase = PH_END;
               end
            end
            default: begin
               if (!pressed) begin
                  phase = PH_IDLE;
                  rest_timer = '0;
                  clear_pending = 1'b1;
                  st = ST_DONE;
               end
            end
         endcase
      end
      word = '{status: st, gesture: held, short_event: ev_short,
               double_event: ev_double, long_event: ev_long};
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         cfg = RESET_CFG;
         phase = PH_IDLE;
         phase_timer = '0;
         rest_timer = '1;
         clear_pending = 1'b0;
         held = G_NONE;
         expected_words.delete();
         failures = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (reg_index_type'(csr_mon.index))
               REG_ACTIVE_HIGH:   cfg.active_high = csr_mon.data[0];
               REG_DOUBLE_ENABLE: cfg.double_enable = csr_mon.data[0];
               REG_LONG_ONCE:     cfg.long_once = csr_mon.data[0];
               REG_HOLD_TICKS:    cfg.hold_ticks = csr_mon.data;
               REG_REST_TICKS:    cfg.rest_ticks = csr_mon.data;
               REG_LONG_TICKS:    cfg.long_ticks = csr_mon.data;
               REG_DOUBLE_WINDOW: cfg.double_window_ticks = csr_mon.data;
               REG_DEBOUNCE:      cfg.debounce_ticks = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{status: status_type'(rsp_mon.status),
                    gesture: gesture_type'(rsp_mon.gesture),
                    short_event: rsp_mon.short_event,
                    double_event: rsp_mon.double_event,
                    long_event: rsp_mon.long_event};
            if (expected_words.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%t checker: unexpected word: status %0d gesture %0d events %b%b%b",
                           $realtime, got.status, got.gesture, got.short_event,
                           got.double_event, got.long_event);
               end
            end else begin
               want = expected_words.pop_front();
               if (got.status !== want.status || got.gesture !== want.gesture ||
                   got.short_event !== want.short_event ||
                   got.double_event !== want.double_event ||
                   got.long_event !== want.long_event) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%t checker: expected status %0d gesture %0d events %b%b%b, got status %0d gesture %0d events %b%b%b",
                              $realtime, want.status, want.gesture, want.short_event,
                              want.double_event, want.long_event, got.status, got.gesture,
                              got.short_event, got.double_event, got.long_event);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            classify_sample(req_mon.pin_level, want);
            expected_words.push_back(want);
         end
      end
      outstanding = expected_words.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top: drives pin samples and register writes into the classifier and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bgc_pkg::*;

   localparam cfg_type RESET_CFG =
      '{1'b1, 1'b0, 1'b0, 16'd500, 16'd20, 16'd1000, 16'd300, 16'd10};

   logic      clock;
   logic      reset;
   int        failures;
   int        outstanding;
   int        sent;
   bit        req_calm;
   bit        rsp_calm;
   cfg_type   shadow;

   bgc_req_if req_ch ();
   bgc_rsp_if rsp_ch ();
   bgc_csr_if csr_ch ();

   button_gesture_classifier_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   bgc_gesture_checker gesture_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   task automatic send_pin(input logic level);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pin_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_run(input logic level, input int count);
      repeat (count) send_pin(level);
   endtask

   function automatic int pick_len(input int limit);
      return $urandom_range(0, (limit > 60) ? 60 : limit);
   endfunction

   task automatic write_reg(input reg_index_type idx, input cfg_word_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      write_reg(REG_ACTIVE_HIGH, cfg_word_type'(c.active_high));
      write_reg(REG_DOUBLE_ENABLE, cfg_word_type'(c.double_enable));
      write_reg(REG_LONG_ONCE, cfg_word_type'(c.long_once));
      write_reg(REG_HOLD_TICKS, c.hold_ticks);
      write_reg(REG_REST_TICKS, c.rest_ticks);
      write_reg(REG_LONG_TICKS, c.long_ticks);
      write_reg(REG_DOUBLE_WINDOW, c.double_window_ticks);
      write_reg(REG_DEBOUNCE, c.debounce_ticks);
      csr_ch.valid <= 1'b0;
      shadow = c;
      req_calm = ($urandom_range(0, 3) == 0);
   endtask

   function automatic cfg_word_type random_ticks();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return cfg_word_type'($urandom_range(20, 40));
         default: return cfg_word_type'($urandom_range(1, 10));
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.active_high = 1'($urandom_range(0, 1));
      c.double_enable = ($urandom_range(0, 2) != 0);
      c.long_once = 1'($urandom_range(0, 1));
      c.hold_ticks = random_ticks();
      c.rest_ticks = random_ticks();
      c.long_ticks = random_ticks();
      c.double_window_ticks = random_ticks();
      c.debounce_ticks = random_ticks();
      return c;
   endfunction

   // Mostly a release, a press and an optional second press, sized to the current timing.
   task automatic gesture_burst();
      logic down;
      down = shadow.active_high;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6)) send_pin($urandom_range(0, 1) == 1);
      end else begin
         send_run(!down, pick_len(int'(shadow.rest_ticks) + 3));
         if ($urandom_range(0, 3) == 0) begin
            send_run(down, pick_len(int'(shadow.debounce_ticks) + 1));
         end else begin
            send_run(down, pick_len(int'(shadow.debounce_ticks) + int'(shadow.long_ticks) + 4));
         end
         if (shadow.double_enable && $urandom_range(0, 1) == 1) begin
            send_run(!down, pick_len(int'(shadow.double_window_ticks) + 2));
            send_run(down, pick_len(2 * int'(shadow.debounce_ticks) +
                                    int'(shadow.rest_ticks) + 4));
         end
         send_run(!down, 1 + pick_len(3));
      end
   endtask

   task automatic run_segment(input int count);
      int target;
      target = sent + count;
      while (sent < target) gesture_burst();
   endtask

   initial begin : result_sink
      int words;
      words = 0;
      rsp_ch.ready = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         int wait_n;
         if (words % 64 == 0) begin
            rsp_calm = ($urandom_range(0, 2) == 0);
         end
         wait_n = rsp_calm ? 0 : $urandom_range(0, 8);
         if (wait_n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
         words++;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pin_level = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      sent = 0;
      req_calm = 1'b0;
      shadow = RESET_CFG;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset timing: idle samples and a press too brief to pass debounce.
      send_run(1'b0, 2);
      send_pin(1'b1);
      send_run(1'b0, 2);

      // Fast timing so a bounce, a short, a double and a long press fit in a few samples.
      apply_config('{1'b1, 1'b1, 1'b0, 16'd2, 16'd0, 16'd3, 16'd4, 16'd1});
      send_pin(1'b1);
      send_pin(1'b0);
      send_run(1'b1, 2);
      send_run(1'b0, 5);
      send_run(1'b1, 2);
      send_pin(1'b0);
      send_pin(1'b1);
      send_run(1'b0, 2);
      send_run(1'b1, 6);
      send_run(1'b0, 2);

      apply_config('{1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
      run_segment(80);
      apply_config('{1'b1, 1'b1, 1'b1, 16'hFFFF, 16'd1, 16'd5, 16'hFFFF, 16'd1});
      run_segment(100);
      apply_config('{1'b0, 1'b0, 1'b0, 16'd3, 16'hFFFF, 16'hFFFF, 16'd5, 16'hFFFF});
      run_segment(40);
      apply_config(RESET_CFG);
      run_segment(80);
      while (sent < 1300) begin
         apply_config(random_config());
         run_segment(90);
      end

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (failures == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
